// ----- hdl/spfk_pkg.sv -----
package spfk_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_BITS   = WORD_BITS + FRAC_BITS;
  localparam int DIV_STAGES = NUM_BITS / 2;
  localparam int ADDR_BITS  = 4;

  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  // -0.5 in fixed point
  localparam logic signed [WORD_BITS-1:0] NEG_HALF = -(WORD_BITS'(1) << (FRAC_BITS - 1));

  // Register map (index = byte address / 4)
  typedef enum logic [1:0] {
    REG_SIM_SCALE = 2'd0,
    REG_RADIUS    = 2'd1,
    REG_COEFF     = 2'd2,
    REG_VISC      = 2'd3
  } reg_idx_t;

  localparam logic [30:0]          RST_SIM_SCALE = 31'd65536;
  localparam logic [30:0]          RST_RADIUS    = 31'd65536;
  localparam logic signed [31:0]   RST_COEFF     = 32'sd65536;
  localparam logic signed [31:0]   RST_VISC      = 32'sd0;

  typedef struct packed {
    logic [15:0]        pair_tag;
    logic signed [31:0] pos_diff_x;
    logic signed [31:0] pos_diff_y;
    logic signed [31:0] pos_diff_z;
    logic [30:0]        pair_distance;
    logic signed [31:0] pressure_first;
    logic signed [31:0] pressure_second;
    logic [30:0]        inv_density_first;
    logic [30:0]        inv_density_second;
    logic signed [31:0] vel_diff_x;
    logic signed [31:0] vel_diff_y;
    logic signed [31:0] vel_diff_z;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        tag_out;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
  } out_item_t;

  // Signed word from sign and magnitude, saturated
  function automatic logic signed [WORD_BITS-1:0] sat_mag(input logic neg,
                                                          input logic [NUM_BITS-1:0] m);
    logic [NUM_BITS-1:0] lim;
    lim = NUM_BITS'(WMAX);
    if (neg) begin
      if (m > lim + NUM_BITS'(1)) return WMIN;
      return -$signed(m[WORD_BITS-1:0]);
    end
    if (m > lim) return WMAX;
    return $signed(m[WORD_BITS-1:0]);
  endfunction

  // Fixed-point product, magnitude rounded half away from zero
  function automatic logic signed [WORD_BITS-1:0] fmul(input logic signed [WORD_BITS-1:0] a,
                                                       input logic signed [WORD_BITS-1:0] b);
    logic                   neg;
    logic [WORD_BITS-1:0]   ma;
    logic [WORD_BITS-1:0]   mb;
    logic [2*WORD_BITS-1:0] p;
    neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
    ma  = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
    mb  = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);
    p   = ma * mb;
    p   = p + ((2*WORD_BITS)'(1) << (FRAC_BITS - 1));
    return sat_mag(neg, NUM_BITS'(p >> FRAC_BITS));
  endfunction

  function automatic logic signed [WORD_BITS-1:0] sat_add(input logic signed [WORD_BITS-1:0] a,
                                                          input logic signed [WORD_BITS-1:0] b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WMIN : WMAX;
    return s[WORD_BITS-1:0];
  endfunction

  // One restoring division step: {quotient bit, new remainder}
  function automatic logic [WORD_BITS-1:0] div_step(input logic [WORD_BITS-2:0] rem,
                                                    input logic bit_in,
                                                    input logic [WORD_BITS-2:0] d);
    logic [WORD_BITS-1:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
      return {1'b1, t[WORD_BITS-2:0]};
    end
    return {1'b0, t[WORD_BITS-2:0]};
  endfunction

endpackage

// ----- hdl/sph_pair_force_kernel_top.sv -----
// SPH pair force kernel: spiky pressure gradient plus viscosity for one
// neighbour pair, signed Q16.16 with saturation throughout.
// Input channel (in_valid/in_stall/in_data): one pair per transaction.
// Output channel (out_valid/out_stall/out_data): one force per pair, in
// order, tag echoed. Force on the second particle is the negation.
// Configuration: APB-style port at byte addresses 0,4,8,12 (scale, radius,
// gradient coefficient, viscosity term); pready is tied high. Write only
// while no pair is in flight.
// Throughput: one transaction per cycle while the output is not stalled.
// From input acceptance to out_valid a pair passes the multiply and sum
// stages around the radix-4 restoring divider for the pressure term.
// The whole pipeline advances together; when the output is valid and
// stalled every stage holds and in_stall rises, so nothing is lost or
// repeated. Bubbles in the pipeline are still filled while the output
// register is empty.
// Reset (rst_n low, synchronous) clears every valid bit and loads the
// register reset values; payload registers are not reset.
module sph_pair_force_kernel_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  spfk_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output spfk_pkg::out_item_t                out_data,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [spfk_pkg::ADDR_BITS-1:0]     cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int NS = spfk_pkg::DIV_STAGES;
  localparam int NB = spfk_pkg::NUM_BITS;

  typedef struct packed {
    logic [15:0]             tag;
    logic [2:0][31:0]        sd;
    logic [2:0][31:0]        vv;
    logic [31:0]             dterm;
  } side_t;

  // Configuration registers
  logic [30:0]        scale_r, radius_r;
  logic signed [31:0] coeff_r, visc_r;
  spfk_pkg::reg_idx_t cfg_idx;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = spfk_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= spfk_pkg::RST_SIM_SCALE;
      radius_r <= spfk_pkg::RST_RADIUS;
      coeff_r  <= spfk_pkg::RST_COEFF;
      visc_r   <= spfk_pkg::RST_VISC;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        spfk_pkg::REG_SIM_SCALE: scale_r  <= cfg_pwdata[30:0];
        spfk_pkg::REG_RADIUS:    radius_r <= cfg_pwdata[30:0];
        spfk_pkg::REG_COEFF:     coeff_r  <= $signed(cfg_pwdata);
        spfk_pkg::REG_VISC:      visc_r   <= $signed(cfg_pwdata);
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (cfg_idx)
      spfk_pkg::REG_SIM_SCALE: cfg_prdata = {1'b0, scale_r};
      spfk_pkg::REG_RADIUS:    cfg_prdata = {1'b0, radius_r};
      spfk_pkg::REG_COEFF:     cfg_prdata = coeff_r;
      spfk_pkg::REG_VISC:      cfg_prdata = visc_r;
      default:                 cfg_prdata = '0;
    endcase
  end

  // Global advance: whole pipeline holds while the output is stalled
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage A: c, pressure sum, divisor
  logic               a_vld_r;
  logic signed [31:0] a_c_r, a_psum_r;
  logic [30:0]        a_d_r, a_invd1_r, a_invd2_r;
  logic [2:0][31:0]   a_pos_r, a_vel_r;
  logic [15:0]        a_tag_r;
  logic signed [31:0] a_c_nxt, a_psum_nxt;
  logic [30:0]        a_d_nxt;

  always_comb begin
    a_c_nxt    = $signed({1'b0, radius_r}) - $signed({1'b0, in_data.pair_distance});
    a_psum_nxt = spfk_pkg::sat_add(in_data.pressure_first, in_data.pressure_second);
    a_d_nxt    = (in_data.pair_distance == '0) ? 31'd1 : in_data.pair_distance;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_c_r     <= a_c_nxt;
      a_psum_r  <= a_psum_nxt;
      a_d_r     <= a_d_nxt;
      a_invd1_r <= in_data.inv_density_first;
      a_invd2_r <= in_data.inv_density_second;
      a_pos_r   <= {in_data.pos_diff_z, in_data.pos_diff_y, in_data.pos_diff_x};
      a_vel_r   <= {in_data.vel_diff_z, in_data.vel_diff_y, in_data.vel_diff_x};
      a_tag_r   <= in_data.pair_tag;
    end
  end

  // Stage B: first products
  logic               b_vld_r;
  logic signed [31:0] b_h1_r, b_cd1_r, b_psum_r;
  logic [30:0]        b_d_r, b_invd2_r;
  logic [2:0][31:0]   b_sd_r, b_vv_r;
  logic [15:0]        b_tag_r;
  logic [2:0][31:0]   b_sd_nxt, b_vv_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      b_sd_nxt[k] = spfk_pkg::fmul($signed(a_pos_r[k]), $signed({1'b0, scale_r}));
      b_vv_nxt[k] = spfk_pkg::fmul(visc_r, $signed(a_vel_r[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_h1_r    <= spfk_pkg::fmul(spfk_pkg::NEG_HALF, a_c_r);
      b_cd1_r   <= spfk_pkg::fmul(a_c_r, $signed({1'b0, a_invd1_r}));
      b_sd_r    <= b_sd_nxt;
      b_vv_r    <= b_vv_nxt;
      b_psum_r  <= a_psum_r;
      b_d_r     <= a_d_r;
      b_invd2_r <= a_invd2_r;
      b_tag_r   <= a_tag_r;
    end
  end

  // Stage C: coefficient and density products
  logic               c_vld_r;
  logic signed [31:0] c_h2_r, c_psum_r;
  logic [30:0]        c_d_r;
  side_t              c_side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_h2_r         <= spfk_pkg::fmul(b_h1_r, coeff_r);
      c_side_r.dterm <= spfk_pkg::fmul(b_cd1_r, $signed({1'b0, b_invd2_r}));
      c_side_r.sd    <= b_sd_r;
      c_side_r.vv    <= b_vv_r;
      c_side_r.tag   <= b_tag_r;
      c_psum_r       <= b_psum_r;
      c_d_r          <= b_d_r;
    end
  end

  // Stage D: pressure numerator
  logic               d_vld_r;
  logic signed [31:0] d_h_r;
  logic [30:0]        d_d_r;
  side_t              d_side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_h_r    <= spfk_pkg::fmul(c_h2_r, c_psum_r);
      d_d_r    <= c_d_r;
      d_side_r <= c_side_r;
    end
  end

  // Divider: two quotient bits per stage
  logic              dv_vld_r [NS];
  logic              dv_neg_r [NS];
  logic [30:0]       dv_rem_r [NS];
  logic [NB-1:0]     dv_num_r [NS];
  logic [NB-1:0]     dv_quo_r [NS];
  logic [30:0]       dv_d_r   [NS];
  side_t             dv_side_r[NS];
  logic              dv_neg_nxt[NS];
  logic [30:0]       dv_rem_nxt[NS];
  logic [NB-1:0]     dv_num_nxt[NS];
  logic [NB-1:0]     dv_quo_nxt[NS];
  logic [30:0]       dv_d_nxt  [NS];
  side_t             dv_side_nxt[NS];

  always_comb begin
    logic          s_neg;
    logic [30:0]   s_rem;
    logic [NB-1:0] s_num;
    logic [NB-1:0] s_quo;
    logic [30:0]   s_d;
    side_t         s_side;
    logic [31:0]   st1;
    logic [31:0]   st2;
    for (int j = 0; j < NS; j++) begin
      if (j == 0) begin
        s_neg  = d_h_r[31];
        s_num  = {(d_h_r[31] ? 32'(-d_h_r) : 32'(d_h_r)), {spfk_pkg::FRAC_BITS{1'b0}}};
        s_rem  = '0;
        s_quo  = '0;
        s_d    = d_d_r;
        s_side = d_side_r;
      end else begin
        s_neg  = dv_neg_r[j-1];
        s_num  = dv_num_r[j-1];
        s_rem  = dv_rem_r[j-1];
        s_quo  = dv_quo_r[j-1];
        s_d    = dv_d_r[j-1];
        s_side = dv_side_r[j-1];
      end
      st1 = spfk_pkg::div_step(s_rem, s_num[NB-1], s_d);
      st2 = spfk_pkg::div_step(st1[30:0], s_num[NB-2], s_d);
      dv_neg_nxt[j]  = s_neg;
      dv_rem_nxt[j]  = st2[30:0];
      dv_num_nxt[j]  = {s_num[NB-3:0], 2'b00};
      dv_quo_nxt[j]  = {s_quo[NB-3:0], st1[31], st2[31]};
      dv_d_nxt[j]    = s_d;
      dv_side_nxt[j] = s_side;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NS; j++) begin
        dv_neg_r[j]  <= dv_neg_nxt[j];
        dv_rem_r[j]  <= dv_rem_nxt[j];
        dv_num_r[j]  <= dv_num_nxt[j];
        dv_quo_r[j]  <= dv_quo_nxt[j];
        dv_d_r[j]    <= dv_d_nxt[j];
        dv_side_r[j] <= dv_side_nxt[j];
      end
    end
  end

  // Stage P: saturated pressure term
  logic               p_vld_r;
  logic signed [31:0] p_pterm_r;
  side_t              p_side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_pterm_r <= spfk_pkg::sat_mag(dv_neg_r[NS-1], dv_quo_r[NS-1]);
      p_side_r  <= dv_side_r[NS-1];
    end
  end

  // Stage Q: pressure term times scaled difference
  logic             q_vld_r;
  logic [2:0][31:0] q_prod_r;
  side_t            q_side_r;
  logic [2:0][31:0] q_prod_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q_prod_nxt[k] = spfk_pkg::fmul(p_pterm_r, $signed(p_side_r.sd[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_prod_r <= q_prod_nxt;
      q_side_r <= p_side_r;
    end
  end

  // Stage S: add viscosity term
  logic             s_vld_r;
  logic [2:0][31:0] s_sum_r;
  logic [31:0]      s_dterm_r;
  logic [15:0]      s_tag_r;
  logic [2:0][31:0] s_sum_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s_sum_nxt[k] = spfk_pkg::sat_add($signed(q_prod_r[k]), $signed(q_side_r.vv[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_sum_r   <= s_sum_nxt;
      s_dterm_r <= q_side_r.dterm;
      s_tag_r   <= q_side_r.tag;
    end
  end

  // Output register: scale by density term
  logic                o_vld_r;
  spfk_pkg::out_item_t o_data_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      o_data_r.tag_out <= s_tag_r;
      o_data_r.force_x <= spfk_pkg::fmul($signed(s_sum_r[0]), $signed(s_dterm_r));
      o_data_r.force_y <= spfk_pkg::fmul($signed(s_sum_r[1]), $signed(s_dterm_r));
      o_data_r.force_z <= spfk_pkg::fmul($signed(s_sum_r[2]), $signed(s_dterm_r));
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      for (int j = 0; j < NS; j++) dv_vld_r[j] <= 1'b0;
      p_vld_r <= 1'b0;
      q_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      dv_vld_r[0] <= d_vld_r;
      for (int j = 1; j < NS; j++) dv_vld_r[j] <= dv_vld_r[j-1];
      p_vld_r <= dv_vld_r[NS-1];
      q_vld_r <= p_vld_r;
      s_vld_r <= q_vld_r;
      o_vld_r <= s_vld_r;
    end
  end

  assign out_valid = o_vld_r;
  assign out_data  = o_data_r;

endmodule

// ----- hdl/spfk_checker.sv -----
module spfk_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input spfk_pkg::in_item_t             in_data,
  input logic                           out_valid,
  input logic                           out_stall,
  input spfk_pkg::out_item_t            out_data,
  input logic                           cfg_psel,
  input logic                           cfg_penable,
  input logic                           cfg_pwrite,
  input logic [spfk_pkg::ADDR_BITS-1:0] cfg_paddr,
  input logic [31:0]                    cfg_pwdata,
  input logic [31:0]                    cfg_prdata,
  input logic                           cfg_pready
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // No result straight out of reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input only held back by a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // Register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

endmodule

bind sph_pair_force_kernel_top spfk_checker u_spfk_checker (.*);

// ----- tb/sph_pair_force_checker.sv -----
`timescale 1ns / 1ps

module sph_pair_force_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  spfk_pkg::in_item_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  spfk_pkg::out_item_t  out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic                 cfg_pready,
  input  logic [3:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output int                   fail_count,
  output int                   pending,
  output int                   force_count
);
  typedef logic signed [63:0] s64_t;
  localparam s64_t W_HI = 64'sd2147483647;
  localparam s64_t W_LO = -64'sd2147483648;

  s64_t                scale_q, radius_q, coeff_q, visc_q;
  spfk_pkg::out_item_t force_q[$];

  function automatic s64_t clip(input s64_t v);
    if (v > W_HI) return W_HI;
    if (v < W_LO) return W_LO;
    return v;
  endfunction

  // Q16.16 product, magnitude rounded half away from zero, saturated
  function automatic s64_t qmul(input s64_t a, input s64_t b);
    logic [127:0] m;
    logic         neg;
    neg = (a < 0) != (b < 0);
    m = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    m = (m + 128'd32768) >> 16;
    if (neg) return (m > 128'd2147483648) ? W_LO : -s64_t'(m);
    return (m > 128'd2147483647) ? W_HI : s64_t'(m);
  endfunction

  // (a << 16) / d truncated toward zero, saturated
  function automatic s64_t qdiv(input s64_t a, input s64_t d);
    logic [127:0] m;
    m = (128'(a < 0 ? -a : a) << 16) / 128'(d);
    if (a < 0) return (m > 128'd2147483648) ? W_LO : -s64_t'(m);
    return (m > 128'd2147483647) ? W_HI : s64_t'(m);
  endfunction

  function automatic spfk_pkg::out_item_t pair_force(input spfk_pkg::in_item_t p);
    spfk_pkg::out_item_t r;
    s64_t c, h, pt, dt, sd, s;
    s64_t pd[3], vd[3];
    c  = clip(radius_q - s64_t'(p.pair_distance));
    h  = qmul(qmul(qmul(-64'sd32768, c), coeff_q),
              clip(s64_t'(p.pressure_first) + s64_t'(p.pressure_second)));
    pt = qdiv(h, p.pair_distance == 0 ? 64'sd1 : s64_t'(p.pair_distance));
    dt = qmul(qmul(c, s64_t'(p.inv_density_first)), s64_t'(p.inv_density_second));
    pd = '{p.pos_diff_x, p.pos_diff_y, p.pos_diff_z};
    vd = '{p.vel_diff_x, p.vel_diff_y, p.vel_diff_z};
    r.tag_out = p.pair_tag;
    for (int k = 0; k < 3; k++) begin
      sd = qmul(pd[k], scale_q);
      s  = clip(qmul(pt, sd) + qmul(visc_q, vd[k]));
      s  = qmul(s, dt);
      if (k == 0) r.force_x = s[31:0];
      else if (k == 1) r.force_y = s[31:0];
      else r.force_z = s[31:0];
    end
    return r;
  endfunction

  assign pending = force_q.size();

  // shadow registers, predict on input, compare on output
  always @(posedge clk) begin
    spfk_pkg::out_item_t e;
    if (!rst_n) begin
      scale_q <= 64'sd65536; radius_q <= 64'sd65536; coeff_q <= 64'sd65536; visc_q <= 64'sd0;
      force_q.delete();
      fail_count <= 0;
      force_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (spfk_pkg::reg_idx_t'(cfg_paddr[3:2]))
          spfk_pkg::REG_SIM_SCALE: scale_q  <= s64_t'(cfg_pwdata[30:0]);
          spfk_pkg::REG_RADIUS:    radius_q <= s64_t'(cfg_pwdata[30:0]);
          spfk_pkg::REG_COEFF:     coeff_q  <= s64_t'($signed(cfg_pwdata));
          spfk_pkg::REG_VISC:      visc_q   <= s64_t'($signed(cfg_pwdata));
          default: ;
        endcase
      end
      if (in_valid && !in_stall) force_q.push_back(pair_force(in_data));
      if (out_valid && !out_stall) begin
        force_count <= force_count + 1;
        if (force_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected force transaction %p", out_data);
        end else begin
          e = force_q.pop_front();
          if (e !== out_data) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("force mismatch tag %h: expected %h %h %h %h, got %h %h %h %h",
                       e.tag_out, e.tag_out, e.force_x, e.force_y, e.force_z,
                       out_data.tag_out, out_data.force_x, out_data.force_y,
                       out_data.force_z);
          end
        end
      end
    end
  end
endmodule

// ----- tb/sph_pair_force_kernel_top_tb.sv -----
`timescale 1ns / 1ps

module sph_pair_force_kernel_top_tb;
  localparam int LATENCY  = 32;
  localparam int WDOG_MAX = 20000;

  logic                clk, rst_n;
  logic                in_valid, in_stall, out_valid, out_stall;
  spfk_pkg::in_item_t  in_data;
  spfk_pkg::out_item_t out_data;
  logic                cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0]          cfg_paddr;
  logic [31:0]         cfg_pwdata, cfg_prdata;
  int                  fail_count, pending, force_count, idle_cycles, sent;
  logic                hold_long;

  sph_pair_force_kernel_top dut (.*);

  sph_pair_force_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 3);
      3: return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
      4: return 32'(int'($urandom_range(0, 1 << 16)) - (1 << 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rnd_pos();
    case ($urandom_range(5))
      0: return 31'h7fffffff;
      1: return 31'(0);
      2: return 31'($urandom_range(0, 2 << 16));
      3: return 31'($urandom_range(0, 1 << 15));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic spfk_pkg::in_item_t rnd_pair();
    spfk_pkg::in_item_t p;
    p.pair_tag = 16'($urandom);
    p.pos_diff_x = rnd_word(); p.pos_diff_y = rnd_word(); p.pos_diff_z = rnd_word();
    p.pair_distance = rnd_pos();
    p.pressure_first = rnd_word(); p.pressure_second = rnd_word();
    p.inv_density_first = rnd_pos(); p.inv_density_second = rnd_pos();
    p.vel_diff_x = rnd_word(); p.vel_diff_y = rnd_word(); p.vel_diff_z = rnd_word();
    return p;
  endfunction

  task automatic reg_write(input spfk_pkg::reg_idx_t idx, input logic [31:0] v);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // offer one pair, hold until accepted, then, if gaps is set, sometimes a random gap
  task automatic send_pair(input spfk_pkg::in_item_t p, input bit gaps);
    in_valid <= 1; in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (gaps && $urandom_range(3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  task automatic load_setting(input int phase);
    case (phase % 6)
      0: begin reg_write(spfk_pkg::REG_SIM_SCALE, 32'h10000);
               reg_write(spfk_pkg::REG_RADIUS, 32'h10000);
               reg_write(spfk_pkg::REG_COEFF, 32'h10000);
               reg_write(spfk_pkg::REG_VISC, 32'h8000); end
      1: begin reg_write(spfk_pkg::REG_SIM_SCALE, 32'h7fffffff);
               reg_write(spfk_pkg::REG_RADIUS, 32'h7fffffff);
               reg_write(spfk_pkg::REG_COEFF, 32'h80000000);
               reg_write(spfk_pkg::REG_VISC, 32'h7fffffff); end
      2: begin reg_write(spfk_pkg::REG_SIM_SCALE, 32'h0);
               reg_write(spfk_pkg::REG_RADIUS, 32'h0);
               reg_write(spfk_pkg::REG_COEFF, 32'h7fffffff);
               reg_write(spfk_pkg::REG_VISC, 32'h80000000); end
      default: begin
        reg_write(spfk_pkg::REG_SIM_SCALE, $urandom_range(0, 4 << 16));
        reg_write(spfk_pkg::REG_RADIUS, $urandom_range(0, 2 << 16));
        reg_write(spfk_pkg::REG_COEFF, rnd_word());
        reg_write(spfk_pkg::REG_VISC, rnd_word());
      end
    endcase
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    bit long_done;
    long_done = 1'b0;
    out_stall = 1;
    @(posedge rst_n);
    forever begin
      if (hold_long && !long_done) begin
        out_stall <= 1;
        repeat (200) @(posedge clk);
        long_done = 1'b1;
      end else if (force_count < 300 || $urandom_range(2) != 0) begin
        out_stall <= 0;
        @(posedge clk);
      end else begin
        out_stall <= 1;
        repeat ($urandom_range(7) == 0 ? $urandom_range(8, 30) : $urandom_range(1, 3))
          @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("** sph_pair_force_kernel_top: FAILED **");
      $finish;
    end
  end

  initial begin
    spfk_pkg::in_item_t p;
    in_valid = 0; in_data = '0; hold_long = 0; sent = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    rst_n = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: reset registers, extremes, zero distance, beyond radius
    for (int i = 0; i < 20; i++) begin
      p = rnd_pair();
      p.pair_tag = 16'(i);
      case (i)
        0: p.pair_distance = 0;
        1: p.pair_distance = 31'h7fffffff;
        2: p = '1;
        3: p = '0;
        4: begin p.pair_distance = 31'(1 << 17); p.pressure_first = 32'h10000; end
        5: begin p.pressure_first = 32'h7fffffff; p.pressure_second = 32'h7fffffff; end
        6: begin p.pressure_first = 32'h80000000; p.pressure_second = 32'h80000000; end
        7: begin p.inv_density_first = 31'h7fffffff; p.inv_density_second = 31'h7fffffff;
                 p.pair_distance = 0; end
        8: begin p.pos_diff_x = 32'h80000000; p.vel_diff_y = 32'h80000000; end
        default: ;
      endcase
      send_pair(p, 0);
    end
    in_valid <= 0;
    wait_drained();
    // random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      load_setting(ph);
      if (ph == 3) hold_long = 1;
      for (int i = 0; i < 200; i++) send_pair(rnd_pair(), ph != 3 && (i % 60) > 20);
      in_valid <= 0;
      wait_drained();
    end
    if (fail_count == 0 && pending == 0) begin
      $display("covered %0d pairs, %0d forces, 9 register settings incl. extremes",
               sent, force_count);
      $display("** sph_pair_force_kernel_top: PASSED **");
    end else begin
      $display("covered %0d pairs, %0d failures", sent, fail_count);
      $display("** sph_pair_force_kernel_top: FAILED **");
    end
    $finish;
  end
endmodule

// ----- sph_pair_force_kernel_top.f -----
hdl/spfk_pkg.sv
hdl/sph_pair_force_kernel_top.sv
hdl/spfk_checker.sv
tb/sph_pair_force_checker.sv
tb/sph_pair_force_kernel_top_tb.sv
